// ===== hdl/histogram_max_normalize_defines.svh =====
// ----------------------------------------------------------------------------
// Histogram max normalize assertion macros
// Shared property forms for the checker of the histogram block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_MAX_NORMALIZE_DEFINES_SVH
`define HISTOGRAM_MAX_NORMALIZE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HMN_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/hmn_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram max normalize package
// Field widths, operation codes and payload types of the histogram block.
// ----------------------------------------------------------------------------
package hmn_pkg;

   localparam int OP_W     = 2;
   localparam int PIXEL_W  = 8;
   localparam int HEIGHT_W = 10;
   localparam int COUNT_W  = 21;

   localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;

   localparam logic [HEIGHT_W-1:0] SCALE_RESET = 10'd400;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [PIXEL_W-1:0] pixel_value;
   } hmn_req_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] bin_height;
      logic [COUNT_W-1:0]  bin_count;
   } hmn_rsp_type;

endpackage

// ===== hdl/hmn_divider.sv =====
// ----------------------------------------------------------------------------
// Histogram max normalize divider
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in HEIGHT_W bits (dividend below divisor shifted up by HEIGHT_W).
// ----------------------------------------------------------------------------
module hmn_divider
   import hmn_pkg::*;
#(
   parameter int COUNT_BITS = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [COUNT_BITS+HEIGHT_W-1:0] dividend,
   input  logic [COUNT_BITS-1:0]          divisor,
   output logic                           done,
   output logic [HEIGHT_W-1:0]            quotient
);

   localparam int STEP_W = $clog2(HEIGHT_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [HEIGHT_W-1:0]   shift_ff, shift_in;
   logic [HEIGHT_W-1:0]   quot_ff, quot_in;

   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  fits;

   // shared subtract-compare step
   assign trial = {rem_ff, shift_ff[HEIGHT_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shift_in   = shift_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = dividend[COUNT_BITS+HEIGHT_W-1:HEIGHT_W];
         shift_in   = dividend[HEIGHT_W-1:0];
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         shift_in = {shift_ff[HEIGHT_W-2:0], 1'b0};
         quot_in  = {quot_ff[HEIGHT_W-2:0], fits};
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_W'(HEIGHT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      shift_ff   <= shift_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== hdl/histogram_max_normalize.sv =====
// ----------------------------------------------------------------------------
// Histogram max normalize
// Bin histogram of pixel values with a readout scaled to the largest bin.
// ----------------------------------------------------------------------------
// The block keeps BIN_COUNT bin counters in a single-port-write memory and
// tracks the largest count. An accumulate transfer adds one to the bin of the
// pixel (saturating at MAX_PIXELS, out-of-range bins ignored). A read
// transfer returns the raw count and floor(count * scale_height / max_count),
// 0 while the maximum is 0; it passes through the memory read, one multiply
// and a restoring divider that retires one quotient bit a cycle. A clear
// transfer sweeps the memory one entry a cycle. After reset the same sweep
// runs with req_stall high; csr writes are taken at any time. Operation code
// 3 is dropped. The result sits in an output register, so new requests are
// taken while a result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module histogram_max_normalize
   import hmn_pkg::*;
#(
   parameter int BIN_COUNT  = 256,
   parameter int MAX_PIXELS = 1048576
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hmn_req_type         req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hmn_rsp_type         rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [HEIGHT_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(BIN_COUNT);
   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int PROD_W = CNT_W + HEIGHT_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // bin store
   logic [CNT_W-1:0]    bins_mem [BIN_COUNT];
   logic [CNT_W-1:0]    rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [CNT_W-1:0]    mem_wdata;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                idx_ok_ff, idx_ok_in;
   logic [CNT_W-1:0]    max_ff, max_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [HEIGHT_W-1:0] scale_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   hmn_rsp_type         rsp_data_ff, rsp_data_in;

   logic [31:0]         pix_wide;
   logic [ADDR_W-1:0]   pix_addr;
   logic                pix_ok;
   logic                req_xfer;
   logic                rsp_free;
   logic [CNT_W-1:0]    bumped;
   logic                div_start;
   logic                div_done;
   logic [HEIGHT_W-1:0] div_quot;

   // map the pixel onto a bin address; anything past the last bin is out
   assign pix_wide = 32'(req_data.pixel_value);
   assign pix_addr = pix_wide[ADDR_W-1:0];
   assign pix_ok   = pix_wide < 32'(BIN_COUNT);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // saturate the bin at MAX_PIXELS
   assign bumped = (rdata_ff < CNT_W'(MAX_PIXELS)) ? rdata_ff + 1'b1 : rdata_ff;

   assign div_start = (state_ff == ST_MUL);

   hmn_divider #(
      .COUNT_BITS (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (max_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      addr_in      = addr_ff;
      idx_ok_in    = idx_ok_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      height_in    = height_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = bumped;

      case (state_ff)
         ST_CLEAR: begin
            // zero one entry a cycle
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(BIN_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               addr_in   = pix_addr;
               idx_ok_in = pix_ok;
               case (req_data.operation)
                  OP_ACCUMULATE: begin
                     if (pix_ok) begin
                        state_in = ST_ACC;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     sweep_in = '0;
                     max_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC: begin
            // write back the bumped count and track the maximum
            mem_we = 1'b1;
            if (bumped > max_ff) begin
               max_in = bumped;
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            count_in = idx_ok_ff ? rdata_ff : '0;
            prod_in  = PROD_W'(idx_ok_ff ? rdata_ff : '0) * PROD_W'(scale_ff);
            if (max_ff == '0) begin
               height_in = '0;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               height_in = div_quot;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_data_in.bin_height = height_ff;
               rsp_data_in.bin_count  = COUNT_W'(count_ff);
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= bins_mem[pix_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         max_ff       <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            scale_ff <= csr_data;
         end
      end
      addr_ff     <= addr_in;
      idx_ok_ff   <= idx_ok_in;
      count_ff    <= count_in;
      prod_ff     <= prod_in;
      height_ff   <= height_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/hmn_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram max normalize checker
// Port-level properties of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`include "histogram_max_normalize_defines.svh"

module hmn_checker
   import hmn_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input hmn_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input hmn_rsp_type rsp_data
);

   `HMN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `HMN_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "stalled result changed")
   `HMN_ASSERT_NEXT(a_read_busy, clock, reset, req_valid && !req_stall && (req_data.operation == OP_READ), req_stall, "read did not occupy the block")
   `HMN_ASSERT_NEXT(a_clear_busy, clock, reset, req_valid && !req_stall && (req_data.operation == OP_CLEAR), req_stall, "clear did not start a sweep")
   `HMN_ASSERT_IMPLY(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared without a read in flight")

endmodule

bind histogram_max_normalize hmn_checker u_checker (.*);

// ===== bench/tb_histogram_max_normalize.sv =====
// ----------------------------------------------------------------------------
// Histogram max normalize testbench
// Drives pixel, read, clear and ignored-code transfers into the histogram
// block, keeps its own bin store and maximum, and checks every normalized
// readout field by field against the predicted height and count.
// ----------------------------------------------------------------------------
module tb_histogram_max_normalize
   import hmn_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Run the block at its default size, so every pixel value has a bin and
   // a bin saturates only at the full pixel limit.
   localparam int BINS          = 256;
   localparam int SAT_LIMIT     = 1048576;
   // A clear sweep is the slowest thing the block does without a result.
   localparam int SETTLE_CYCLES = BINS + 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;

   // Code that the block drops without effect.
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   hmn_req_type         req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   hmn_rsp_type         rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [HEIGHT_W-1:0] csr_data  = '0;

   // Pixel transfers waiting to be offered, and readouts still to arrive.
   hmn_req_type pending_reqs[$];
   hmn_rsp_type expected_bins[$];

   // Shadow histogram: bin counts, largest count and scale height.
   logic [COUNT_W-1:0]  model_bins[BINS];
   logic [COUNT_W-1:0]  model_max;
   logic [HEIGHT_W-1:0] model_scale;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        hold_go       = 1'b0;
   logic        hold_rsp      = 1'b0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   histogram_max_normalize #(
      .BIN_COUNT  (BINS),
      .MAX_PIXELS (SAT_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Apply one accepted transfer to the shadow histogram; a read queues the
   // readout it must produce.
   function automatic void predict_histogram(input hmn_req_type item);
      logic [COUNT_W-1:0] count;
      logic [63:0]        product;
      hmn_rsp_type        readout;
      bit                 in_range;
      in_range = int'(item.pixel_value) < BINS;
      case (item.operation)
         OP_ACCUMULATE: begin
            // Drop pixels whose bin does not exist; hold a full bin.
            if (in_range) begin
               count = model_bins[item.pixel_value];
               if (count < COUNT_W'(SAT_LIMIT)) count = count + 1'b1;
               model_bins[item.pixel_value] = count;
               if (count > model_max) model_max = count;
            end
         end
         OP_CLEAR: begin
            foreach (model_bins[i]) model_bins[i] = '0;
            model_max = '0;
         end
         OP_READ: begin
            count = in_range ? model_bins[item.pixel_value] : '0;
            // Empty histogram reads as zero height.
            if (model_max == '0) begin
               readout.bin_height = '0;
            end else begin
               product = 64'(count) * 64'(model_scale);
               readout.bin_height = HEIGHT_W'(product / 64'(model_max));
            end
            readout.bin_count = count;
            expected_bins.push_back(readout);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic hmn_req_type req_item(input logic [OP_W-1:0] op,
                                            input logic [PIXEL_W-1:0] pixel);
      hmn_req_type item;
      item.operation   = op;
      item.pixel_value = pixel;
      return item;
   endfunction

   // Queue random transfers. hot_pct of the pixels land on hot_pixel, which
   // lets one bin run well ahead of the rest and pushes the maximum around.
   task automatic queue_random(input int unsigned count, input logic [PIXEL_W-1:0] hot_pixel,
                               input int unsigned hot_pct, input int unsigned acc_pct,
                               input int unsigned clear_pct);
      int unsigned roll;
      logic [OP_W-1:0]    op;
      logic [PIXEL_W-1:0] pixel;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < clear_pct) op = OP_CLEAR;
         else if (roll < clear_pct + 3) op = OP_IGNORED;
         else if (roll < clear_pct + 3 + acc_pct) op = OP_ACCUMULATE;
         else op = OP_READ;
         if ($urandom_range(99) < hot_pct) pixel = hot_pixel;
         else pixel = PIXEL_W'($urandom_range(255));
         pending_reqs.push_back(req_item(op, pixel));
      end
   endtask

   // Set the idle rates away from the clock edge, where the driver and the
   // monitor read them.
   task automatic start_phase(input int unsigned send_pct, input int unsigned recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Wait until every transfer is in and every readout is out, then let a
   // trailing clear sweep finish.
   task automatic drain_and_settle();
      while (pending_reqs.size() != 0 || req_valid || expected_bins.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hold the scale write until the block takes it.
   task automatic write_scale(input logic [HEIGHT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Driver: advance to the next pending transfer once the current one is
   // taken, idling at random. The shadow histogram follows every transfer on
   // either channel at the edge where it happens.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         foreach (model_bins[i]) model_bins[i] = '0;
         model_max   = '0;
         model_scale = SCALE_RESET;
      end else begin
         if (csr_valid && csr_ready) model_scale = csr_data;
         if (req_valid && !req_stall) predict_histogram(req_data);
         // Hold a stalled payload; otherwise offer the next one or idle.
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each readout taken against the oldest expectation, and
   // stall at random or for the long hold-off.
   always @(posedge clock) begin
      hmn_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bins.size() == 0) begin
               $error("readout with none expected: bin_height %0d, bin_count %0d",
                      rsp_data.bin_height, rsp_data.bin_count);
               fail_count = fail_count + 1;
            end else begin
               want = expected_bins.pop_front();
               if (rsp_data.bin_height !== want.bin_height) begin
                  $error("bin_height mismatch: expected %0d, actual %0d",
                         want.bin_height, rsp_data.bin_height);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.bin_count !== want.bin_count) begin
                  $error("bin_count mismatch: expected %0d, actual %0d",
                         want.bin_count, rsp_data.bin_count);
                  fail_count = fail_count + 1;
               end
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Long hold-off on the readout side, counted here, so that reads pile up
   // behind the output register and the block stalls its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** histogram_max_normalize: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, the first and last bins, the ignored code,
      // clear and a read right after it, at the reset scale.
      start_phase(24, 86);
      pending_reqs.push_back(req_item(OP_READ, 8'd0));
      pending_reqs.push_back(req_item(OP_READ, 8'd255));
      pending_reqs.push_back(req_item(OP_ACCUMULATE, 8'd0));
      pending_reqs.push_back(req_item(OP_ACCUMULATE, 8'd0));
      pending_reqs.push_back(req_item(OP_ACCUMULATE, 8'd255));
      pending_reqs.push_back(req_item(OP_ACCUMULATE, 8'(BINS - 1)));
      pending_reqs.push_back(req_item(OP_ACCUMULATE, 8'd5));
      pending_reqs.push_back(req_item(OP_READ, 8'd0));
      pending_reqs.push_back(req_item(OP_READ, 8'(BINS - 1)));
      pending_reqs.push_back(req_item(OP_READ, 8'(BINS)));
      pending_reqs.push_back(req_item(OP_READ, 8'd255));
      pending_reqs.push_back(req_item(OP_READ, 8'd5));
      pending_reqs.push_back(req_item(OP_IGNORED, 8'd255));
      pending_reqs.push_back(req_item(OP_IGNORED, 8'd0));
      pending_reqs.push_back(req_item(OP_READ, 8'd0));
      pending_reqs.push_back(req_item(OP_CLEAR, 8'd170));
      pending_reqs.push_back(req_item(OP_READ, 8'd0));
      pending_reqs.push_back(req_item(OP_ACCUMULATE, 8'd128));
      pending_reqs.push_back(req_item(OP_READ, 8'd128));
      pending_reqs.push_back(req_item(OP_READ, 8'd127));
      queue_random(250, 8'($urandom_range(255)), 10, 67, 1);
      drain_and_settle();

      // Full scale; run one bin far ahead of the rest with reads mixed in.
      write_scale(10'd1023);
      start_phase(24, 86);
      queue_random(350, 8'($urandom_range(BINS - 1)), 95, 90, 0);
      drain_and_settle();

      // Zero scale: every height reads zero.
      write_scale(10'd0);
      start_phase(86, 24);
      queue_random(150, 8'($urandom_range(255)), 10, 67, 1);
      drain_and_settle();

      write_scale(HEIGHT_W'($urandom_range(1022, 2)));
      start_phase(86, 24);
      queue_random(250, 8'($urandom_range(15)), 50, 67, 2);
      drain_and_settle();

      // Smallest scale, no idling, and the long readout hold-off.
      write_scale(10'd1);
      start_phase(0, 0);
      queue_random(250, 8'($urandom_range(255)), 30, 60, 1);
      hold_go = 1'b1;
      drain_and_settle();

      write_scale(HEIGHT_W'($urandom_range(1023, 1)));
      start_phase(0, 0);
      queue_random(100, 8'($urandom_range(255)), 20, 60, 5);
      drain_and_settle();

      if (fail_count == 0) begin
         $display("** histogram_max_normalize: PASSED **");
      end else begin
         $display("** histogram_max_normalize: FAILED **");
      end
      $finish;
   end

endmodule

// ===== histogram_max_normalize.f =====
+incdir+hdl
hdl/hmn_pkg.sv
hdl/hmn_divider.sv
hdl/histogram_max_normalize.sv
hdl/hmn_checker.sv
bench/tb_histogram_max_normalize.sv
